// ----- rtl/bhpq_pkg.sv -----
// Shared types and constants for the binary heap priority queue.
// Holds controller states, result status codes, register indexes and the
// command/status structs that join the controller and the datapath.
package bhpq_pkg;

  // Configuration port geometry
  localparam int CFG_W = 32;
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Register indexes (address bit 2 selects the register)
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  // Operation codes on the input channel
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CHK,
    S_DN_CMP,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;        // latch status and extracted key for a new transaction
    st_t  status;       // status code to latch on start
    logic op_ins;       // begin insert: hole at end, count up
    logic op_ext;       // begin extract: count down, read last entry
    logic rd_children;  // read address selects left/right child
    logic load_last;    // take last entry as moving key, hole at root
    logic wr_key;       // write moving key into the hole
    logic up_step;      // move parent down into the hole
    logic dn_step;      // move chosen child up into the hole
    logic out_load;     // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic pos_zero;
    logic up_move;
    logic dn_leaf;
    logic dn_move;
  } dp_sts_t;

endpackage

// ----- rtl/bhpq_dp.sv -----
// Datapath of the binary heap priority queue: heap memory, moving key,
// hole position, fill count and result registers.
// Depends on bhpq_pkg for the command/status structs and status codes.
module bhpq_dp #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 32,
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       heap_mode,
  input  logic [bhpq_pkg::CAP_W-1:0] capacity,
  input  logic [KEY_WIDTH-1:0]       key_in,
  input  bhpq_pkg::dp_cmd_t          cmd,
  output bhpq_pkg::dp_sts_t          sts,
  output logic [KEY_WIDTH-1:0]       key_out,
  output logic [KEY_WIDTH-1:0]       top_key,
  output logic [CW-1:0]              entry_count,
  output logic [1:0]                 status
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = AW + 1;
  localparam int LW = (CW > bhpq_pkg::CAP_W) ? CW : bhpq_pkg::CAP_W;

  // Heap memory, one write and two registered reads per cycle
  logic [KEY_WIDTH-1:0] mem [DEPTH];

  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] k_r, k_nxt;
  logic [KEY_WIDTH-1:0] top_r;
  logic [KEY_WIDTH-1:0] rd0_r, rd1_r;
  logic [KEY_WIDTH-1:0] key_res_r;
  bhpq_pkg::st_t        status_r;
  logic [KEY_WIDTH-1:0] key_out_r, top_out_r;
  logic [CW-1:0]        cnt_out_r;
  bhpq_pkg::st_t        st_out_r;

  logic [AW-1:0]        pos_dec, parent_a, last_a, ra0, ra1, child_a;
  logic [CW-1:0]        count_dec;
  logic [XW-1:0]        left_x, right_x, count_x;
  logic                 r_ok, take_l, take_r;
  logic [KEY_WIDTH-1:0] best_v, child_v, wd;
  logic                 we;

  // Strict heap order: a belongs above b
  function automatic logic above(input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b,
                                 input logic                 mode);
    return mode ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

  // Address arithmetic
  assign pos_dec   = pos_r - AW'(1);
  assign parent_a  = pos_dec >> 1;
  assign count_dec = count_r - CW'(1);
  assign last_a    = count_dec[AW-1:0];
  assign left_x    = {pos_r, 1'b1};
  assign right_x   = left_x + XW'(1);
  assign count_x   = XW'(count_r);

  // Child selection for sift-down; left wins a tie
  assign r_ok    = right_x < count_x;
  assign take_l  = above(rd0_r, k_r, heap_mode);
  assign best_v  = take_l ? rd0_r : k_r;
  assign take_r  = r_ok && above(rd1_r, best_v, heap_mode);
  assign child_v = take_r ? rd1_r : rd0_r;
  assign child_a = take_r ? right_x[AW-1:0] : left_x[AW-1:0];

  // Status toward the controller
  always_comb begin
    sts.full     = (LW'(count_r) >= LW'(capacity)) || (count_r == CW'(DEPTH));
    sts.empty    = (count_r == '0);
    sts.last_one = (count_r == CW'(1));
    sts.pos_zero = (pos_r == '0);
    sts.up_move  = above(k_r, rd0_r, heap_mode);
    sts.dn_leaf  = (left_x >= count_x);
    sts.dn_move  = take_l | take_r;
  end

  // Memory port selection
  assign ra0 = cmd.op_ext ? last_a : (cmd.rd_children ? left_x[AW-1:0] : parent_a);
  assign ra1 = right_x[AW-1:0];
  assign we  = cmd.wr_key | cmd.up_step | cmd.dn_step;
  assign wd  = cmd.up_step ? rd0_r : (cmd.dn_step ? child_v : k_r);

  // Write the hole, mirror the root, read two addresses
  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos_r] <= wd;
      if (pos_r == '0) begin
        top_r <= wd;
      end
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  // Next count, hole position and moving key
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    if (cmd.op_ins) begin
      count_nxt = count_r + CW'(1);
      pos_nxt   = count_r[AW-1:0];
      k_nxt     = key_in;
    end
    if (cmd.op_ext) begin
      count_nxt = count_dec;
    end
    if (cmd.load_last) begin
      pos_nxt = '0;
      k_nxt   = rd0_r;
    end
    if (cmd.up_step) begin
      pos_nxt = parent_a;
    end
    if (cmd.dn_step) begin
      pos_nxt = child_a;
    end
  end

  // Hold the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    k_r   <= k_nxt;
    if (cmd.start) begin
      status_r  <= cmd.status;
      key_res_r <= cmd.op_ext ? top_r : '0;
    end
    if (cmd.out_load) begin
      key_out_r <= key_res_r;
      top_out_r <= (count_r != '0) ? top_r : '0;
      cnt_out_r <= count_r;
      st_out_r  <= status_r;
    end
  end

  assign key_out     = key_out_r;
  assign top_key     = top_out_r;
  assign entry_count = cnt_out_r;
  assign status      = st_out_r;

endmodule

// ----- rtl/bhpq_ctrl.sv -----
// Controller of the binary heap priority queue: sequences insert sift-up,
// extract sift-down and the result handshake.
// Depends on bhpq_pkg for states, status codes and command/status structs.
module bhpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bhpq_pkg::dp_cmd_t cmd,
  input  bhpq_pkg::dp_sts_t sts
);

  bhpq_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bhpq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == bhpq_pkg::OP_INSERT) begin
            state_nxt = sts.full ? bhpq_pkg::S_RESP : bhpq_pkg::S_UP_CHK;
          end else if (sts.empty || sts.last_one) begin
            state_nxt = bhpq_pkg::S_RESP;
          end else begin
            state_nxt = bhpq_pkg::S_DN_LOAD;
          end
        end
      end
      bhpq_pkg::S_UP_CHK: begin
        state_nxt = sts.pos_zero ? bhpq_pkg::S_RESP : bhpq_pkg::S_UP_CMP;
      end
      bhpq_pkg::S_UP_CMP: begin
        state_nxt = sts.up_move ? bhpq_pkg::S_UP_CHK : bhpq_pkg::S_RESP;
      end
      bhpq_pkg::S_DN_LOAD: begin
        state_nxt = bhpq_pkg::S_DN_CHK;
      end
      bhpq_pkg::S_DN_CHK: begin
        state_nxt = sts.dn_leaf ? bhpq_pkg::S_RESP : bhpq_pkg::S_DN_CMP;
      end
      bhpq_pkg::S_DN_CMP: begin
        state_nxt = sts.dn_move ? bhpq_pkg::S_DN_CHK : bhpq_pkg::S_RESP;
      end
      bhpq_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = bhpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = bhpq_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_op == bhpq_pkg::OP_INSERT) begin
            cmd.status = sts.full ? bhpq_pkg::ST_FULL : bhpq_pkg::ST_OK;
            cmd.op_ins = !sts.full;
          end else begin
            cmd.status = sts.empty ? bhpq_pkg::ST_EMPTY : bhpq_pkg::ST_OK;
            cmd.op_ext = !sts.empty;
          end
        end
      end
      bhpq_pkg::S_UP_CHK: begin
        cmd.wr_key = sts.pos_zero;
      end
      bhpq_pkg::S_UP_CMP: begin
        cmd.up_step = sts.up_move;
        cmd.wr_key  = !sts.up_move;
      end
      bhpq_pkg::S_DN_LOAD: begin
        cmd.load_last = 1'b1;
      end
      bhpq_pkg::S_DN_CHK: begin
        cmd.rd_children = 1'b1;
        cmd.wr_key      = sts.dn_leaf;
      end
      bhpq_pkg::S_DN_CMP: begin
        cmd.dn_step = sts.dn_move;
        cmd.wr_key  = !sts.dn_move;
      end
      bhpq_pkg::S_RESP: begin
        cmd.out_load = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // Result valid: set on load, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhpq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/binary_heap_priority_queue.sv -----
// Top level of the binary heap priority queue: configuration registers,
// controller and datapath. Depends on bhpq_pkg, bhpq_ctrl and bhpq_dp.
//
// Keeps up to DEPTH signed keys in a binary heap, smallest or largest on
// top as heap_mode selects; capacity limits the entries in use. One
// transaction is worked at a time. A dropped insert, an extract on an
// empty heap and an extract that leaves the heap empty go from acceptance
// straight to the result. An insert climbs level by level until the key
// reaches the root or stops below it; an extract moves the last entry to
// the root and sinks it until it settles at a leaf or stops above one.
// The key moves at most log2(DEPTH) levels; each level is one registered
// memory read and one compare-and-write through the single heap memory.
// The heap memory needs no clearing after reset; the block is ready for a
// transaction as soon as reset is released. A finished result is held in
// the output register until taken.
module binary_heap_priority_queue #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [KEY_WIDTH-1:0]       in_key_in,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [KEY_WIDTH-1:0]       out_key_out,
  output logic [KEY_WIDTH-1:0]       out_top_key,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  output logic [1:0]                 out_status,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [bhpq_pkg::CFG_W-1:0] pwdata,
  output logic [bhpq_pkg::CFG_W-1:0] prdata,
  output logic                       pready
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                       mode_r, mode_nxt;
  logic [bhpq_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic                       cfg_wr;
  bhpq_pkg::dp_cmd_t          cmd;
  bhpq_pkg::dp_sts_t          sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    mode_nxt = mode_r;
    cap_nxt  = cap_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        bhpq_pkg::REG_MODE: mode_nxt = pwdata[0];
        bhpq_pkg::REG_CAP:  cap_nxt  = pwdata[bhpq_pkg::CAP_W-1:0];
        default:            mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cap_r  <= bhpq_pkg::CAP_RESET;
    end else begin
      mode_r <= mode_nxt;
      cap_r  <= cap_nxt;
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      bhpq_pkg::REG_MODE: prdata = bhpq_pkg::CFG_W'(mode_r);
      bhpq_pkg::REG_CAP:  prdata = bhpq_pkg::CFG_W'(cap_r);
      default:            prdata = '0;
    endcase
  end

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bhpq_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .CW        (CW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .heap_mode   (mode_r),
    .capacity    (cap_r),
    .key_in      (in_key_in),
    .cmd         (cmd),
    .sts         (sts),
    .key_out     (out_key_out),
    .top_key     (out_top_key),
    .entry_count (out_entry_count),
    .status      (out_status)
  );

  // The count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CW'(DEPTH)))
    else $error("entry count beyond depth");

  // A rejected transaction never reports an extracted key
  a_reject_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == bhpq_pkg::ST_FULL ||
                   out_status == bhpq_pkg::ST_EMPTY)) |-> (out_key_out == '0))
    else $error("key reported on rejected transaction");

  // An extract on an empty heap reports an empty heap
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bhpq_pkg::ST_EMPTY) |->
      (out_entry_count == '0 && out_top_key == '0))
    else $error("empty status with entries held");

  // One transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

endmodule
